### hdl/yprc_pkg.sv
// Shared types and constants for the yaw PI rate controller.
// No dependencies; imported by the controller top level.
`timescale 1ns / 1ps

package yprc_pkg;

    // Integral accumulator width, Q.28 fraction
    localparam int INTEG_WIDTH = 40;
    // Serial product: 40 bit integral times a 16 bit gain, plus headroom for the
    // proportional term added 16 places up
    localparam int PROD_W      = INTEG_WIDTH + 17;
    // Raw command in Q.20 after dropping 16 fraction bits of the product
    localparam int RAW_W       = PROD_W - 16;

    localparam int MUL_BITS    = 16;
    localparam int CNT_W       = $clog2(MUL_BITS);

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STEP = 2'd3;

    localparam logic signed [15:0] PROP_GAIN_RST    = 16'sd51;
    localparam logic signed [15:0] INTEG_GAIN_RST   = 16'sd0;
    localparam logic        [14:0] MAX_RATE_RST     = 15'd4915;
    localparam logic        [13:0] DEFAULT_STEP_RST = 14'd1311;

    localparam logic        [14:0] RATE_MIN  = 15'd41;
    localparam logic        [13:0] STEP_MIN  = 14'd1;
    localparam logic        [13:0] STEP_MAX  = 14'd13107;

    // Angles in Q4.12, held in 17 bits for the raw difference
    localparam logic signed [16:0] ANG_PI     = 17'sd12868;
    localparam logic signed [16:0] ANG_TWO_PI = 17'sd25736;

    typedef struct packed {
        logic signed [15:0] target;
        logic               rate_mode;
        logic signed [15:0] measured_yaw;
        logic        [15:0] time_step;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] rate_command;
        logic               limited;
    } t_out_beat;

endpackage

### hdl/yaw_pi_rate_controller.sv
// Yaw PI rate controller: sequencer with a bit-serial shift-add multiplier.
// Depends on yprc_pkg for beat types, widths and constants.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_stall / i_in) takes one control tick per
//   beat: target, mode, measured yaw and time step. Output channel
//   (o_out_valid / i_out_stall / o_out) gives one rate command per tick.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
//   write it only while no tick is in flight.
// Sequencing
//   Rate mode: the target passes from accept through the finish (clamp) state
//   to the output register; the finish state holds while a full output stalls.
//   Attitude mode: error wrap (one add of two pi per cycle), three passes of
//   the shared serial multiplier (error * dt, ki * integral, kp * error) with
//   a saturating add after the first, then the clamp. The multiplier retires
//   one multiplier bit per cycle. One tick is worked on at a time; the next
//   is taken as soon as the result has moved to the output register.
// Reset
//   Registers return to their reset values, the integral clears and the
//   first tick after reset clears it again as a mode change would.
// Stall
//   A finished result waits in the output register; a second finished result
//   holds in the clamp stage until the first beat is taken.

module yaw_pi_rate_controller
    import yprc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WRAP   = 3'd1;
    localparam logic [2:0] ST_MUL_DT = 3'd2;
    localparam logic [2:0] ST_SATADD = 3'd3;
    localparam logic [2:0] ST_MUL_KI = 3'd4;
    localparam logic [2:0] ST_MUL_KP = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_BITS - 1);

    // configuration
    logic signed [15:0] r_kp, r_ki;
    logic        [14:0] r_max_rate;
    logic        [13:0] r_def_step;

    // controller state
    logic signed [INTEG_WIDTH-1:0] r_integ, n_integ;
    logic                          r_prev_mode, n_prev_mode;
    logic                          r_mode_seen, n_mode_seen;

    // sequencer and working registers
    logic [2:0]                    r_state, n_state;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic                          r_mode, n_mode;
    logic signed [15:0]            r_tgt, n_tgt;
    logic signed [16:0]            r_err, n_err;
    logic        [13:0]            r_dt, n_dt;
    logic signed [INTEG_WIDTH-1:0] r_next, n_next;
    logic signed [PROD_W-1:0]      r_mcand, n_mcand;
    logic        [MUL_BITS-1:0]    r_mplier, n_mplier;
    logic signed [PROD_W-1:0]      r_acc, n_acc;

    logic                          r_out_valid, n_out_valid;
    t_out_beat                     r_out, n_out;

    logic                          in_acc, out_acc, can_go;
    logic        [15:0]            ts;
    logic signed [PROD_W-1:0]      partial, acc_step;
    logic signed [INTEG_WIDTH:0]   sum;
    logic signed [INTEG_WIDTH-1:0] next_sat;
    logic signed [RAW_W-1:0]       raw, lim20, nlim20, clamped;
    logic                          high, low, err_pos, err_neg;
    logic        [14:0]            cfg_rate;
    logic        [13:0]            cfg_step;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign can_go      = !r_out_valid || !i_out_stall;
    assign ts          = i_in.time_step;

    // one multiplier bit per cycle; the top gain bit weighs negative
    assign partial  = r_mplier[0] ? r_mcand : '0;
    assign acc_step = (r_cnt == CNT_LAST) ? r_acc - partial : r_acc + partial;

    // saturating integral add of error * dt
    always_comb begin
        sum = {r_integ[INTEG_WIDTH-1], r_integ} + r_acc[INTEG_WIDTH:0];
        if (sum[INTEG_WIDTH] != sum[INTEG_WIDTH-1]) begin
            next_sat = sum[INTEG_WIDTH] ? {1'b1, {(INTEG_WIDTH-1){1'b0}}}
                                        : {1'b0, {(INTEG_WIDTH-1){1'b1}}};
        end else begin
            next_sat = sum[INTEG_WIDTH-1:0];
        end
    end

    // clamp against max rate in Q.20
    always_comb begin
        if (r_mode) begin
            raw = {{(RAW_W-24){r_tgt[15]}}, r_tgt, 8'b0};
        end else begin
            raw = r_acc[PROD_W-1:16];
        end
        lim20  = {{(RAW_W-23){1'b0}}, r_max_rate, 8'b0};
        nlim20 = -lim20;
        high   = raw > lim20;
        low    = raw < nlim20;
        priority if (high) begin
            clamped = lim20;
        end else if (low) begin
            clamped = nlim20;
        end else begin
            clamped = raw;
        end
        err_pos = !r_err[16] && (r_err != '0);
        err_neg = r_err[16];
    end

    always_comb begin
        cfg_rate = i_cfg_data[14:0];
        if (cfg_rate < RATE_MIN) begin
            cfg_rate = RATE_MIN;
        end
        cfg_step = i_cfg_data[13:0];
        if (cfg_step < STEP_MIN) begin
            cfg_step = STEP_MIN;
        end else if (cfg_step > STEP_MAX) begin
            cfg_step = STEP_MAX;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_mode      = r_mode;
        n_tgt       = r_tgt;
        n_err       = r_err;
        n_dt        = r_dt;
        n_next      = r_next;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_acc       = r_acc;
        n_integ     = r_integ;
        n_prev_mode = r_prev_mode;
        n_mode_seen = r_mode_seen;
        n_out       = r_out;
        n_out_valid = out_acc ? 1'b0 : r_out_valid;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_mode = i_in.rate_mode;
                    n_tgt  = i_in.target;
                    n_err  = 17'(i_in.target) - 17'(i_in.measured_yaw);
                    n_dt   = (ts == '0 || ts > 16'(STEP_MAX)) ? r_def_step : ts[13:0];
                    // mode change, or first tick after reset: drop the integral
                    if (!r_mode_seen || i_in.rate_mode != r_prev_mode) begin
                        n_integ     = '0;
                        n_prev_mode = i_in.rate_mode;
                        n_mode_seen = 1'b1;
                    end
                    n_state = i_in.rate_mode ? ST_FINISH : ST_WRAP;
                end
            end
            ST_WRAP: begin
                priority if (r_err > ANG_PI) begin
                    n_err = r_err - ANG_TWO_PI;
                end else if (r_err < -ANG_PI) begin
                    n_err = r_err + ANG_TWO_PI;
                end else begin
                    n_mcand  = {{(PROD_W-17){r_err[16]}}, r_err};
                    n_mplier = {2'b00, r_dt};
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_state  = ST_MUL_DT;
                end
            end
            ST_MUL_DT, ST_MUL_KI, ST_MUL_KP: begin
                n_acc    = acc_step;
                n_mcand  = r_mcand <<< 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    unique case (r_state)
                        ST_MUL_DT: n_state = ST_SATADD;
                        ST_MUL_KI: begin
                            // add kp * error sixteen places up into the same sum
                            n_mcand  = {{(PROD_W-33){r_err[16]}}, r_err, 16'b0};
                            n_mplier = r_kp;
                            n_state  = ST_MUL_KP;
                        end
                        default: n_state = ST_FINISH;
                    endcase
                end
            end
            ST_SATADD: begin
                n_next   = next_sat;
                n_mcand  = {{(PROD_W-INTEG_WIDTH){next_sat[INTEG_WIDTH-1]}}, next_sat};
                n_mplier = r_ki;
                n_acc    = '0;
                n_state  = ST_MUL_KI;
            end
            ST_FINISH: begin
                if (can_go) begin
                    n_out.rate_command = clamped[23:8];
                    n_out.limited      = high || low;
                    n_out_valid        = 1'b1;
                    // conditional integration, attitude mode only: hold the
                    // integral while pushing further into the limit
                    if (!r_mode && !((high && err_pos) || (low && err_neg))) begin
                        n_integ = r_next;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_prev_mode <= 1'b0;
            r_mode_seen <= 1'b0;
            r_kp        <= PROP_GAIN_RST;
            r_ki        <= INTEG_GAIN_RST;
            r_max_rate  <= MAX_RATE_RST;
            r_def_step  <= DEFAULT_STEP_RST;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_integ     <= n_integ;
            r_prev_mode <= n_prev_mode;
            r_mode_seen <= n_mode_seen;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PROP_GAIN:    r_kp       <= i_cfg_data;
                    CFG_INTEG_GAIN:   r_ki       <= i_cfg_data;
                    CFG_MAX_RATE:     r_max_rate <= cfg_rate;
                    CFG_DEFAULT_STEP: r_def_step <= cfg_step;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_tgt    <= n_tgt;
        r_err    <= n_err;
        r_dt     <= n_dt;
        r_next   <= n_next;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
        r_out    <= n_out;
    end

    // the command held for the receiver never exceeds the limit in force
    a_cmd_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_cfg_we) |->
            ($signed(o_out.rate_command) <= $signed({1'b0, r_max_rate}) &&
             $signed(o_out.rate_command) >= -$signed({1'b0, r_max_rate})))
        else $error("rate command outside max rate");

    // the bit counter is back at zero whenever no multiply pass runs
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_MUL_DT && r_state != ST_MUL_KI && r_state != ST_MUL_KP)
            |-> (r_cnt == '0))
        else $error("multiplier counter left mid pass");

    // the wrapped error never leaves plus or minus pi once multiplying
    a_err_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL_DT) |-> (r_err <= ANG_PI && r_err >= -ANG_PI))
        else $error("angle error not wrapped");

    // the integral moves only on a tick accept or when a result is committed
    a_integ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_FINISH && !in_acc) |=> (r_integ == $past(r_integ)))
        else $error("integral changed outside accept or commit");

endmodule

### bench/yaw_pi_rate_controller_tb.sv
// Self-checking bench for the yaw PI rate controller: directed ticks, random
// runs over many register settings and integral wind-up in both directions.
// Depends on yprc_pkg and yaw_pi_rate_controller.
`timescale 1ns / 1ps

module yaw_pi_rate_controller_tb;
    import yprc_pkg::*;

    // Scoreboard: own copy of the controller state, predicts one command per
    // tick and checks the output beats against them in order.
    class yaw_cmd_scoreboard;
        int      kp;
        int      ki;
        int      rate_lim;
        int      step_dflt;
        longint  integ;
        bit      prior_mode;
        bit      primed;
        t_out_beat cmd_q[$];
        int      n_err;
        int      n_ticks;
        int      n_limited;
        int      n_writes;

        function new();
            kp         = int'(PROP_GAIN_RST);
            ki         = int'(INTEG_GAIN_RST);
            rate_lim   = int'(MAX_RATE_RST);
            step_dflt  = int'(DEFAULT_STEP_RST);
            integ      = 0;
            prior_mode = 1'b0;
            primed     = 1'b0;
            n_err      = 0;
            n_ticks    = 0;
            n_limited  = 0;
            n_writes   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int v;
            n_writes++;
            case (idx)
                CFG_PROP_GAIN: kp = int'($signed(data));
                CFG_INTEG_GAIN: ki = int'($signed(data));
                CFG_MAX_RATE: begin
                    v = int'(data[14:0]);
                    rate_lim = (v < int'(RATE_MIN)) ? int'(RATE_MIN) : v;
                end
                CFG_DEFAULT_STEP: begin
                    v = int'(data[13:0]);
                    if (v < int'(STEP_MIN)) v = int'(STEP_MIN);
                    if (v > int'(STEP_MAX)) v = int'(STEP_MAX);
                    step_dflt = v;
                end
                default: ;
            endcase
        endfunction

        function void note_tick(t_in_beat b);
            int        tgt, yaw, dt, err, cmd;
            longint    nxt, prop, hi, lo, raw, lim20, top, bot;
            bit        high, low, lim;
            t_out_beat e;
            tgt = int'($signed(b.target));
            yaw = int'($signed(b.measured_yaw));
            dt  = int'(b.time_step);
            if (dt == 0 || dt > int'(STEP_MAX)) dt = step_dflt;
            // first tick after reset or a mode change starts from a clear integral
            if (!primed || b.rate_mode != prior_mode) begin
                integ      = 0;
                prior_mode = b.rate_mode;
                primed     = 1'b1;
            end
            if (b.rate_mode) begin
                lim = (tgt > rate_lim) || (tgt < -rate_lim);
                cmd = (tgt > rate_lim) ? rate_lim : ((tgt < -rate_lim) ? -rate_lim : tgt);
            end else begin
                err = tgt - yaw;
                while (err > int'(ANG_PI)) err -= int'(ANG_TWO_PI);
                while (err < -int'(ANG_PI)) err += int'(ANG_TWO_PI);
                top = (longint'(1) <<< (INTEG_WIDTH - 1)) - 1;
                bot = -top - 1;
                nxt = integ + longint'(err) * longint'(dt);
                if (nxt > top) nxt = top;
                if (nxt < bot) nxt = bot;
                prop  = longint'(kp) * longint'(err);
                hi    = nxt >>> 16;
                lo    = nxt - hi * 65536;
                raw   = prop + longint'(ki) * hi + ((longint'(ki) * lo) >>> 16);
                lim20 = longint'(rate_lim) * 256;
                high  = raw > lim20;
                low   = raw < -lim20;
                lim   = high || low;
                if (high) raw = lim20;
                else if (low) raw = -lim20;
                cmd = int'(raw >>> 8);
                // conditional integration: hold while pushing further into the rail
                if (!((high && err > 0) || (low && err < 0))) integ = nxt;
            end
            e.rate_command = cmd[15:0];
            e.limited      = lim;
            cmd_q.push_back(e);
            n_ticks++;
            if (lim) n_limited++;
        endfunction

        function void check_command(t_out_beat got);
            t_out_beat e;
            if (cmd_q.size() == 0) begin
                $error("output beat with no tick outstanding: rate_command %0d limited %0b",
                       $signed(got.rate_command), got.limited);
                n_err++;
                return;
            end
            e = cmd_q.pop_front();
            if (got.rate_command !== e.rate_command) begin
                $error("rate_command: expected %0d, actual %0d",
                       $signed(e.rate_command), $signed(got.rate_command));
                n_err++;
            end
            if (got.limited !== e.limited) begin
                $error("limited: expected %0b, actual %0b", e.limited, got.limited);
                n_err++;
            end
        endfunction

        function int pending();
            return cmd_q.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_PROP_GAIN;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    t_in_beat              in_beat     = '0;
    logic                  out_stall   = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_beat             out_beat;

    int send_idle = 0;
    int recv_idle = 0;
    int n_settings = 0;

    yaw_cmd_scoreboard sb = new();

    yaw_pi_rate_controller DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    always #10 i_clk = ~i_clk;

    // Receiver: stall at random at the current idle rate
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // Watch both channels; values seen here are those the block saw at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && !out_stall) sb.check_command(out_beat);
            if (in_valid && !in_stall) sb.note_tick(in_beat);
        end
    end

    // Present one tick, idling first at random, and hold it until accepted
    task automatic send_tick(t_in_beat b);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic tick(int tgt, bit mode, int yaw, int dt);
        t_in_beat b;
        b.target       = tgt[15:0];
        b.rate_mode    = mode;
        b.measured_yaw = yaw[15:0];
        b.time_step    = dt[15:0];
        send_tick(b);
    endtask

    // Drop valid and wait until every outstanding command has come back
    task automatic settle();
        in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Write all four registers; call only with the block drained
    task automatic load_settings(int kp, int ki, int mx, int st);
        write_one(CFG_PROP_GAIN, kp[15:0]);
        write_one(CFG_INTEG_GAIN, ki[15:0]);
        write_one(CFG_MAX_RATE, mx[15:0]);
        write_one(CFG_DEFAULT_STEP, st[15:0]);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic int rand_gain();
        logic [15:0] g;
        g = 16'($urandom);
        if ($urandom_range(1)) g = {{5{g[10]}}, g[10:0]};
        return int'($signed(g));
    endfunction

    function automatic int rand_step();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r <= 2) return $urandom_range(13108, 65535);
        return $urandom_range(1, 13107);
    endfunction

    task automatic rand_tick(bit mode);
        int tgt, yaw;
        tgt = $urandom_range(65535) - 32768;
        if ($urandom_range(1)) yaw = $urandom_range(65535) - 32768;
        else yaw = tgt + $urandom_range(1200) - 600;
        tick(tgt, mode, yaw, rand_step());
    endtask

    // Runs of one mode with random content; odd single ticks of either mode as noise
    task automatic random_runs(int n_items);
        int  left, run;
        bit  mode;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(9) == 0) begin
                rand_tick($urandom_range(1));
                left--;
            end else begin
                mode = ($urandom_range(3) == 0);
                run  = mode ? $urandom_range(1, 8) : $urandom_range(2, 40);
                while (run > 0 && left > 0) begin
                    rand_tick(mode);
                    run--;
                    left--;
                end
            end
        end
    endtask

    // Wind the integral up in one direction with zero gains, then show it through ki
    task automatic wind_up(bit positive);
        int tgt, yaw, dt;
        settle();
        load_settings(0, 0, 32767, int'(STEP_MAX));
        repeat (100) begin
            if (positive) begin
                tgt = $urandom_range(12868, 32767);
                yaw = tgt - 12868 + $urandom_range(50);
            end else begin
                tgt = $urandom_range(19899) - 32768;
                yaw = tgt + 12868 - $urandom_range(50);
            end
            dt = $urandom_range(3) == 0 ? 0 : $urandom_range(13000, 13107);
            tick(tgt, 1'b0, yaw, dt);
        end
        settle();
        load_settings(0, positive ? 1 : -32768, 32767, int'(STEP_MAX));
        repeat (6) tick(100, 1'b0, 100, 13107);
        repeat (4) tick(positive ? 12868 : -12868, 1'b0, 0, 13107);
        repeat (4) tick(positive ? -3000 : 3000, 1'b0, 0, 13107);
        tick(0, 1'b1, 0, 0);
    endtask

    initial begin
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed ticks at the reset settings
        send_idle = 19;
        recv_idle = 81;
        tick(0, 1'b0, 0, 0);
        tick(12868, 1'b0, 0, 13107);
        tick(-12868, 1'b0, 0, 13108);
        tick(12869, 1'b0, 0, 65535);
        tick(-12869, 1'b0, 0, 1);
        tick(32767, 1'b0, -32768, 100);
        tick(-32768, 1'b0, 32767, 200);
        tick(32767, 1'b0, 0, 32768);
        tick(1000, 1'b0, -1000, 13107);
        tick(-5000, 1'b0, 4000, 0);
        tick(32767, 1'b1, 0, 0);
        tick(-32768, 1'b1, 32767, 65535);
        tick(4915, 1'b1, 0, 13107);
        tick(-4915, 1'b1, 0, 1);
        tick(4916, 1'b1, 0, 13108);
        tick(-4916, 1'b1, -32768, 7);
        tick(0, 1'b1, 32767, 43690);
        tick(12868, 1'b0, -12868, 21845);
        tick(-100, 1'b0, 100, 13107);

        // Random runs: three idle regimes, each over several register settings
        k = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 19 : ((ph == 1) ? 81 : 0);
            recv_idle = (ph == 0) ? 81 : ((ph == 1) ? 19 : 0);
            for (int sub = 0; sub < 6; sub++) begin
                settle();
                case (k)
                    0: load_settings(32767, 32767, 16'h0000, 16'h0000);
                    1: load_settings(-32768, -32768, 16'hFFFF, 16'hFFFF);
                    2: load_settings(0, 0, 40, 13108);
                    3: load_settings(51, 0, 41, 1);
                    4: load_settings(256, 64, 32767, 13107);
                    default: load_settings(rand_gain(), rand_gain(), $urandom_range(65535),
                                           $urandom_range(1) ? $urandom_range(65535)
                                                             : $urandom_range(1, 2000));
                endcase
                k++;
                random_runs(70);
            end
        end

        // Wind the integral up positive, then negative
        wind_up(1'b1);
        wind_up(1'b0);

        settle();
        repeat (60) @(posedge i_clk);
        $display("Run covered %0d control ticks (%0d limited) over %0d register settings,",
                 sb.n_ticks, sb.n_limited, n_settings);
        $display("%0d register writes, integral wound up in both directions; %0d mismatches.",
                 sb.n_writes, sb.n_err);
        if (sb.n_err == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #(64'd60_000_000);
        $display("Timed out with %0d commands outstanding.", sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
